/* rtl/core/vibration_pattern_sequencer_top_macros.svh */
`ifndef VIBRATION_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define VIBRATION_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vps_pkg.sv */
package vps_pkg;

    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int ENTRY_IDX_W = 4;
    localparam int ENTRY_VAL_W = 16;
    localparam int ON_TIME_W   = 16;
    localparam int TDATA_W     = 24;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_ZERO_LOOP = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 1'd0,
        REG_REPEAT_INDEX   = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TICK,
        SEQ_STEP,
        SEQ_ON,
        SEQ_NEXT,
        SEQ_OFF,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic                 motor_on;
        logic [ON_TIME_W-1:0] on_time;
        logic                 motor_off;
        logic                 playing;
        logic                 finished;
        status_t              status;
    } vps_result_t;

    typedef struct packed {
        logic                   wr_en;
        logic [ENTRY_IDX_W-1:0] wr_index;
        logic                   rd_en;
        logic [LEN_W-1:0]       rd_index;
        logic [LEN_W-1:0]       scan_from;
        logic [LEN_W-1:0]       scan_to;
    } vps_mem_req_t;

endpackage

/* rtl/core/vps_store.sv */
module vps_store #(
    parameter int PATTERN_DEPTH = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vps_pkg::vps_mem_req_t      mem_req,
    input  logic [DURATION_BITS-1:0]   wr_data,
    output logic [DURATION_BITS-1:0]   rd_data,
    output logic                       any_nonzero
);
    import vps_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_DEPTH);
    // Entries at or above 32 can never fall inside a 5-bit range.
    localparam int SCAN  = (PATTERN_DEPTH < 32) ? PATTERN_DEPTH : 32;

    logic [DURATION_BITS-1:0] mem [PATTERN_DEPTH];
    logic [DURATION_BITS-1:0] rd_data_reg;
    logic [PATTERN_DEPTH-1:0] marks_reg;
    logic                     wr_ok;

    assign wr_ok = mem_req.wr_en && (32'(mem_req.wr_index) < 32'(PATTERN_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[IDX_W'(mem_req.wr_index)] <= wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[IDX_W'(mem_req.rd_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (wr_ok)
        begin
            marks_reg[IDX_W'(mem_req.wr_index)] <= (wr_data != '0);
        end
    end

    always_comb
    begin
        any_nonzero = 1'b0;
        for (int i = 0; i < SCAN; i++)
        begin
            if (marks_reg[i] && (LEN_W'(i) >= mem_req.scan_from)
                && (LEN_W'(i) < mem_req.scan_to))
            begin
                any_nonzero = 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/vps_seq.sv */
`include "vibration_pattern_sequencer_top_macros.svh"

module vps_seq #(
    parameter int PATTERN_DEPTH = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  vps_pkg::cmd_t                       in_cmd,
    input  logic [vps_pkg::ENTRY_IDX_W-1:0]     in_entry_index,
    input  logic [vps_pkg::ENTRY_VAL_W-1:0]     in_entry_value,
    input  logic [vps_pkg::LEN_W-1:0]           pattern_length,
    input  logic [vps_pkg::LEN_W-1:0]           repeat_index,
    input  logic                                out_free,
    output logic                                idle,
    output logic                                res_valid,
    output vps_pkg::vps_result_t                result,
    output vps_pkg::vps_mem_req_t               mem_req,
    output logic [DURATION_BITS-1:0]            wr_data,
    input  logic [DURATION_BITS-1:0]            rd_data,
    input  logic                                any_nonzero
);
    import vps_pkg::*;

    localparam int ACC_W   = DURATION_BITS + 1;
    localparam int LEN_CAP = (PATTERN_DEPTH > 31) ? 31 : PATTERN_DEPTH;

    seq_state_t       state_reg, state_next;
    logic             active_reg, active_next;
    logic [LEN_W-1:0] pi_reg, pi_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    vps_result_t      res_reg, res_next;

    logic [LEN_W-1:0] len_eff;
    logic             rep_neg;
    logic             pi_lt_len;
    logic [ACC_W-1:0] opa, opb, sum;
    logic [31:0]      rd_wide;
    logic [31:0]      val_wide;

    assign len_eff   = (32'(pattern_length) > 32'(LEN_CAP)) ? LEN_W'(LEN_CAP) : pattern_length;
    assign rep_neg   = repeat_index[LEN_W-1];
    assign pi_lt_len = pi_reg < len_eff;
    assign rd_wide   = 32'(rd_data);
    assign val_wide  = 32'(in_entry_value);
    assign wr_data   = val_wide[DURATION_BITS-1:0];

    // Shared adder: load, accumulate and count down the wait.
    always_comb
    begin
        opa = (state_reg == SEQ_ON) ? '0 : acc_reg;
        unique case (state_reg)
            SEQ_TICK: opb = (acc_reg != '0) ? '1 : '0;
            default:  opb = {1'b0, rd_data};
        endcase
        sum = opa + opb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            active_reg <= 1'b0;
            pi_reg     <= '0;
            acc_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            pi_reg     <= pi_next;
            acc_reg    <= acc_next;
            res_reg    <= res_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        pi_next     = pi_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        res_valid   = 1'b0;

        mem_req.wr_en     = 1'b0;
        mem_req.wr_index  = in_entry_index;
        mem_req.rd_en     = 1'b0;
        mem_req.rd_index  = pi_reg;
        mem_req.scan_from = '0;
        mem_req.scan_to   = len_eff;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    state_next = SEQ_DONE;
                    unique case (in_cmd)
                        CMD_LOAD:
                        begin
                            mem_req.wr_en = 1'b1;
                        end
                        CMD_START:
                        begin
                            if ((len_eff == '0) || !any_nonzero
                                || (!rep_neg && (repeat_index >= len_eff)))
                            begin
                                res_next.status = ST_REJECT;
                            end
                            else
                            begin
                                res_next.motor_off = 1'b1;
                                active_next        = 1'b1;
                                pi_next            = '0;
                                acc_next           = '0;
                                state_next         = SEQ_NEXT;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (active_reg)
                            begin
                                state_next = SEQ_TICK;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            active_next        = 1'b0;
                            acc_next           = '0;
                            pi_next            = '0;
                            res_next.motor_off = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            SEQ_TICK:
            begin
                acc_next   = sum;
                state_next = (sum == '0) ? SEQ_STEP : SEQ_DONE;
            end
            SEQ_STEP:
            begin
                mem_req.scan_from = repeat_index;
                if (pi_lt_len)
                begin
                    mem_req.rd_en = 1'b1;
                    state_next    = SEQ_ON;
                end
                else if (rep_neg || !any_nonzero)
                begin
                    // Natural end, or a pass from the repeat point that never waits.
                    active_next        = 1'b0;
                    acc_next           = '0;
                    pi_next            = '0;
                    res_next.motor_off = 1'b1;
                    res_next.finished  = rep_neg;
                    res_next.status    = rep_neg ? ST_OK : ST_ZERO_LOOP;
                    state_next         = SEQ_DONE;
                end
                else
                begin
                    pi_next    = repeat_index;
                    acc_next   = '0;
                    state_next = SEQ_NEXT;
                end
            end
            SEQ_ON:
            begin
                acc_next = sum;
                pi_next  = pi_reg + 1'b1;
                if (rd_data != '0)
                begin
                    res_next.motor_on = 1'b1;
                    res_next.on_time  = rd_wide[ON_TIME_W-1:0];
                end
                state_next = SEQ_NEXT;
            end
            SEQ_NEXT:
            begin
                if (pi_lt_len)
                begin
                    mem_req.rd_en = 1'b1;
                    state_next    = SEQ_OFF;
                end
                else
                begin
                    state_next = (acc_reg != '0) ? SEQ_DONE : SEQ_STEP;
                end
            end
            SEQ_OFF:
            begin
                acc_next   = sum;
                pi_next    = pi_reg + 1'b1;
                state_next = (sum != '0) ? SEQ_DONE : SEQ_STEP;
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        res_next.playing = active_next;
    end

    assign idle   = (state_reg == SEQ_IDLE);
    assign result = res_reg;

    `VPS_ASSERT_IMPLY(a_stopped_no_wait, !active_reg, acc_reg == '0,
        "wait count left behind after playback stopped")
    `VPS_ASSERT_IMPLY(a_playing_armed, (state_reg == SEQ_IDLE) && active_reg, acc_reg != '0,
        "playback idle with no wait armed")
    `VPS_ASSERT_IMPLY(a_read_issued, (state_reg == SEQ_ON) || (state_reg == SEQ_OFF),
        $past(mem_req.rd_en), "store data used without a read")

endmodule

/* rtl/core/vibration_pattern_sequencer_top.sv */
// Haptic on/off pattern sequencer.
// Input words (s_t*) carry a command in s_tuser: load an entry, start, a one
// millisecond tick, or cancel. Every input word yields exactly one result word
// on m_t*: motor on/off commands, the on time, playing/finished flags and a
// status code in m_tuser.
// The cfg channel writes pattern_length (index 0) and repeat_index (index 1)
// and is always ready; write it only while no word is in flight.
// A load, cancel, start rejection or idle tick goes from acceptance straight to
// the final step; a tick that only counts down passes the countdown step first.
// A tick or start that walks the pattern spends a registered store read and an
// accumulate on each entry it visits, plus end-of-pattern checks at each
// pattern end, over at most about two passes over the pattern.
// One word is in work at a time; s_tready is low while the sequencer walks.
// The finished result sits in an output register, so the next word is taken
// while it waits; a stalled m_tready holds the result and the sequencer
// waits in its final step until the register frees up.
// Reset clears playback, the nonzero marks and the registers (length 0,
// repeat -1); store contents stay undefined until loaded.
`include "vibration_pattern_sequencer_top_macros.svh"

module vibration_pattern_sequencer_top #(
    parameter int PATTERN_DEPTH = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[3:0], entry_value[19:4], zero[23:20]
    input  logic [vps_pkg::TDATA_W-1:0]         s_tdata,
    // cmd[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // motor_on[0], on_time[16:1], motor_off[17], playing[18], finished[19],
    // zero[23:20]
    output logic [vps_pkg::TDATA_W-1:0]         m_tdata,
    // status[1:0]
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vps_pkg::LEN_W-1:0]           cfg_data
);
    import vps_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] rep_reg;
    logic             m_valid_reg;
    vps_result_t      out_reg;

    logic                     seq_idle;
    logic                     res_valid;
    vps_result_t              result;
    vps_mem_req_t             mem_req;
    logic [DURATION_BITS-1:0] wr_data;
    logic [DURATION_BITS-1:0] rd_data;
    logic                     any_nonzero;
    logic                     out_free;
    logic                     in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = seq_idle;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            rep_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: len_reg <= cfg_data;
                REG_REPEAT_INDEX:   rep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= result;
        end
    end

    vps_seq #(
        .PATTERN_DEPTH(PATTERN_DEPTH),
        .DURATION_BITS(DURATION_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_accept),
        .in_cmd         (cmd_t'(s_tuser)),
        .in_entry_index (s_tdata[ENTRY_IDX_W-1:0]),
        .in_entry_value (s_tdata[ENTRY_IDX_W +: ENTRY_VAL_W]),
        .pattern_length (len_reg),
        .repeat_index   (rep_reg),
        .out_free       (out_free),
        .idle           (seq_idle),
        .res_valid      (res_valid),
        .result         (result),
        .mem_req        (mem_req),
        .wr_data        (wr_data),
        .rd_data        (rd_data),
        .any_nonzero    (any_nonzero)
    );

    vps_store #(
        .PATTERN_DEPTH(PATTERN_DEPTH),
        .DURATION_BITS(DURATION_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_req     (mem_req),
        .wr_data     (wr_data),
        .rd_data     (rd_data),
        .any_nonzero (any_nonzero)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.finished, out_reg.playing, out_reg.motor_off,
                       out_reg.on_time, out_reg.motor_on};
    assign m_tuser  = out_reg.status;

    `VPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "word accepted while the sequencer was still busy")
    `VPS_ASSERT_IMPLY(a_on_not_finished, m_tvalid, !(m_tdata[0] && m_tdata[19]),
        "motor-on issued on the word that ends the pattern")
    `VPS_ASSERT_IMPLY(a_finished_stops, m_tvalid && m_tdata[19], !m_tdata[18] && m_tdata[17],
        "finished word still playing or without motor off")
    `VPS_ASSERT_IMPLY(a_reject_quiet, m_tvalid && (m_tuser == ST_REJECT),
        !m_tdata[0] && !m_tdata[17], "rejected start drove the motor")

endmodule

/* test/vibration_pattern_sequencer_top_tb.sv */
module vibration_pattern_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vps_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int DEPTH          = 16;
    localparam int WALK_CAP       = 4 * DEPTH + 8;
    localparam int RANDOM_WORDS   = 1850;
    localparam int SETTLE_CYCLES  = 6;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 24;
    localparam logic [LEN_W-1:0] REP_ONCE = 5'h1f;
    localparam vps_result_t UNFIXED = '0;

    typedef struct {
        bit                     is_reg;
        cfg_reg_t               reg_sel;
        logic [LEN_W-1:0]       reg_val;
        cmd_t                   cmd;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [ENTRY_VAL_W-1:0] val;
        bit                     fixed;
        vps_result_t            want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LEN_W-1:0]       cfg_data;

    // sequencer mirror
    logic [ENTRY_VAL_W-1:0] slot_ms [DEPTH];
    logic [DEPTH-1:0]       slot_set;
    logic [LEN_W-1:0]       step_pos;
    logic [16:0]            ms_left;
    bit                     is_playing;
    logic [LEN_W-1:0]       reg_len;
    logic [LEN_W-1:0]       reg_rep;

    vps_result_t motor_words_due [$];

    int  words_sent;
    int  reg_writes;
    int  results_seen;
    int  bad_fields;
    int  natural_ends;
    int  zero_loops;
    int  rejects;
    bit  src_steady;
    bit  squeeze_req;
    bit  squeeze_done;

    vibration_pattern_sequencer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int used_len();
        return (int'(reg_len) > DEPTH) ? DEPTH : int'(reg_len);
    endfunction

    function automatic int rep_val();
        return int'($signed(reg_rep));
    endfunction

    function automatic bit marked_between(int lo, int hi);
        for (int i = lo; i < hi && i < DEPTH; i++)
        begin
            if (slot_set[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic stop_playback(inout vps_result_t r, input status_t st, input bit natural);
        is_playing  = 1'b0;
        ms_left     = '0;
        step_pos    = '0;
        r.motor_off = 1'b1;
        r.status    = st;
        r.finished  = natural;
    endtask

    // Walk entries until a nonzero wait is loaded or playback stops.
    task automatic walk_pattern(input bit at_top, inout vps_result_t r);
        int          len;
        int          rep;
        logic [16:0] acc;
        bit          top;
        len = used_len();
        rep = rep_val();
        acc = '0;
        top = at_top;
        for (int n = 0; n < WALK_CAP; n++)
        begin
            if (!top)
            begin
                if (int'(step_pos) < len)
                begin
                    acc = {1'b0, slot_ms[step_pos]};
                    step_pos++;
                    if (acc != 0)
                    begin
                        r.motor_on = 1'b1;
                        r.on_time  = acc[ON_TIME_W-1:0];
                    end
                end
                else if (rep < 0)
                begin
                    stop_playback(r, ST_OK, 1'b1);
                    return;
                end
                else
                begin
                    if (!marked_between(rep, len))
                    begin
                        stop_playback(r, ST_ZERO_LOOP, 1'b0);
                        return;
                    end
                    step_pos = 5'(rep);
                    acc      = '0;
                end
            end
            top = 1'b0;
            if (int'(step_pos) < len)
            begin
                acc = acc + {1'b0, slot_ms[step_pos]};
                step_pos++;
            end
            if (acc != 0)
            begin
                ms_left = acc;
                return;
            end
        end
        stop_playback(r, ST_ZERO_LOOP, 1'b0);
    endtask

    task automatic play_step(input cmd_t cmd, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic [ENTRY_VAL_W-1:0] val, output vps_result_t r);
        int len;
        int rep;
        r = '0;
        case (cmd)
            CMD_LOAD:
            begin
                slot_ms[idx]  = val;
                slot_set[idx] = (val != 0);
            end
            CMD_START:
            begin
                len = used_len();
                rep = rep_val();
                if (len == 0 || !marked_between(0, len) || rep >= len)
                    r.status = ST_REJECT;
                else
                begin
                    r.motor_off = 1'b1;
                    is_playing  = 1'b1;
                    step_pos    = '0;
                    ms_left     = '0;
                    walk_pattern(1'b1, r);
                end
            end
            CMD_TICK:
            begin
                if (is_playing)
                begin
                    if (ms_left > 0)
                        ms_left--;
                    if (ms_left == 0)
                        walk_pattern(1'b0, r);
                end
            end
            default:
                stop_playback(r, ST_OK, 1'b0);
        endcase
        r.playing = is_playing;
    endtask

    function automatic vps_result_t outcome(bit on, logic [ON_TIME_W-1:0] t, bit off,
                                            bit play, bit fin, status_t st);
        vps_result_t r;
        r.motor_on  = on;
        r.on_time   = t;
        r.motor_off = off;
        r.playing   = play;
        r.finished  = fin;
        r.status    = st;
        return r;
    endfunction

    function automatic plan_row_t word_row(cmd_t c, logic [ENTRY_IDX_W-1:0] i,
                                           logic [ENTRY_VAL_W-1:0] v, bit fixed,
                                           vps_result_t w);
        plan_row_t p;
        p.is_reg  = 1'b0;
        p.reg_sel = REG_PATTERN_LENGTH;
        p.reg_val = '0;
        p.cmd     = c;
        p.idx     = i;
        p.val     = v;
        p.fixed   = fixed;
        p.want    = w;
        return p;
    endfunction

    function automatic plan_row_t reg_row(cfg_reg_t s, logic [LEN_W-1:0] d);
        plan_row_t p;
        p         = word_row(CMD_LOAD, '0, '0, 1'b0, UNFIXED);
        p.is_reg  = 1'b1;
        p.reg_sel = s;
        p.reg_val = d;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ENTRY_VAL_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return '0;
        if (r < 88)
            return 16'($urandom_range(1, 4));
        if (r < 95)
            return 16'($urandom_range(5, 40));
        return 16'($urandom());
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return 5'd16;
        if (r < 24)
            return 5'd31;
        if (r < 32)
            return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 8));
    endfunction

    function automatic logic [LEN_W-1:0] pick_repeat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return REP_ONCE;
        if (r < 43)
            return 5'h10;
        if (r < 50)
            return 5'd15;
        if (r < 60)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    task automatic send_word(input cmd_t cmd, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic [ENTRY_VAL_W-1:0] val, input bit fixed,
                             input vps_result_t want);
        vps_result_t r;
        int          gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        play_step(cmd, idx, val, r);
        motor_words_due.push_back(fixed ? want : r);
        words_sent++;
    endtask

    // Drain the block, then write one register.
    task automatic write_reg(input cfg_reg_t sel, input logic [LEN_W-1:0] data);
        s_tvalid <= 1'b0;
        while (motor_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == REG_PATTERN_LENGTH)
            reg_len = data;
        else
            reg_rep = data;
        reg_writes++;
    endtask

    task automatic flag_bad_field(string what, longint got_v, longint want_v);
        bad_fields++;
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 results_seen, what, got_v, want_v);
    endtask

    task automatic check_field(string what, longint got_v, longint want_v);
        if (got_v != want_v)
            flag_bad_field(what, got_v, want_v);
    endtask

    always @(posedge clk)
    begin : watch_results
        vps_result_t got;
        vps_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.motor_on  = m_tdata[0];
            got.on_time   = m_tdata[16:1];
            got.motor_off = m_tdata[17];
            got.playing   = m_tdata[18];
            got.finished  = m_tdata[19];
            got.status    = status_t'(m_tuser);
            if (motor_words_due.size() == 0)
                flag_bad_field("result word with nothing pending", 1, 0);
            else
            begin
                want = motor_words_due.pop_front();
                check_field("motor_on", got.motor_on, want.motor_on);
                check_field("on_time", got.on_time, want.on_time);
                check_field("motor_off", got.motor_off, want.motor_off);
                check_field("playing", got.playing, want.playing);
                check_field("finished", got.finished, want.finished);
                check_field("status", longint'(got.status), longint'(want.status));
                if (want.finished)
                    natural_ends++;
                if (want.status == ST_ZERO_LOOP)
                    zero_loops++;
                if (want.status == ST_REJECT)
                    rejects++;
            end
            results_seen++;
        end
    end

    initial
    begin : sink_side
        int stall;
        int sink_cycles;
        bit steady;
        m_tready    = 1'b0;
        sink_cycles = 0;
        steady      = 1'b0;
        forever
        begin
            @(posedge clk);
            sink_cycles++;
            if (sink_cycles % 256 == 0)
                steady = ($urandom_range(0, 5) == 0);
            stall = 0;
            if (squeeze_req && !squeeze_done)
            begin
                // hold off long enough to back up into the input side
                stall        = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            else if (!steady && $urandom_range(0, 99) < 30)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                sink_cycles += stall;
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles, %0d results pending",
                         quiet_cycles, motor_words_due.size());
                $display("vibration_pattern_sequencer_top_tb failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan [$];
        vps_result_t quiet;
        vps_result_t off_only;
        vps_result_t rejected;
        int          r;
        int          n_ticks;
        bit          first;

        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        for (int k = 0; k < DEPTH; k++)
            slot_ms[k] = '0;
        slot_set     = '0;
        step_pos     = '0;
        ms_left      = '0;
        is_playing   = 1'b0;
        reg_len      = '0;
        reg_rep      = REP_ONCE;
        words_sent   = 0;
        reg_writes   = 0;
        results_seen = 0;
        bad_fields   = 0;
        natural_ends = 0;
        zero_loops   = 0;
        rejects      = 0;
        src_steady   = 1'b0;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;

        quiet    = outcome(1'b0, '0, 1'b0, 1'b0, 1'b0, ST_OK);
        off_only = outcome(1'b0, '0, 1'b1, 1'b0, 1'b0, ST_OK);
        rejected = outcome(1'b0, '0, 1'b0, 1'b0, 1'b0, ST_REJECT);

        // idle after reset: empty length, stray tick, cancel, then load entries 0 to 3
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b1, rejected));
        plan.push_back(word_row(CMD_TICK,   4'd15, 16'hffff,  1'b1, quiet));
        plan.push_back(word_row(CMD_CANCEL, 4'd0,  16'd0,     1'b1, off_only));
        plan.push_back(word_row(CMD_LOAD,   4'd0,  16'd0,     1'b1, quiet));
        plan.push_back(word_row(CMD_LOAD,   4'd1,  16'hffff,  1'b1, quiet));
        plan.push_back(word_row(CMD_LOAD,   4'd2,  16'd1,     1'b1, quiet));
        plan.push_back(word_row(CMD_LOAD,   4'd3,  16'd0,     1'b1, quiet));
        // only a zero entry in use
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 5'd1));
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b1, rejected));
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 5'd4));
        plan.push_back(reg_row(REG_REPEAT_INDEX, REP_ONCE));
        // longest on time, then cancel mid-wait
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b0, UNFIXED));
        plan.push_back(word_row(CMD_CANCEL, 4'd0,  16'd0,     1'b1, off_only));
        plan.push_back(word_row(CMD_LOAD,   4'd1,  16'd2,     1'b1, quiet));
        // play once to a natural end
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b0, UNFIXED));
        for (int k = 0; k < 4; k++)
            plan.push_back(word_row(CMD_TICK, 4'd0, 16'd0, 1'b0, UNFIXED));
        plan.push_back(reg_row(REG_REPEAT_INDEX, 5'd15));
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b1, rejected));
        // loop back, then zero the tail while playing
        plan.push_back(reg_row(REG_REPEAT_INDEX, 5'd2));
        plan.push_back(word_row(CMD_START,  4'd0,  16'd0,     1'b0, UNFIXED));
        for (int k = 0; k < 3; k++)
            plan.push_back(word_row(CMD_TICK, 4'd0, 16'd0, 1'b0, UNFIXED));
        plan.push_back(word_row(CMD_LOAD,   4'd2,  16'd0,     1'b0, UNFIXED));
        for (int k = 0; k < 3; k++)
            plan.push_back(word_row(CMD_TICK, 4'd0, 16'd0, 1'b0, UNFIXED));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_reg)
                write_reg(plan[k].reg_sel, plan[k].reg_val);
            else
                send_word(plan[k].cmd, plan[k].idx, plan[k].val, plan[k].fixed, plan[k].want);
        end

        // fill every slot before any random start reads the store
        for (int k = 0; k < DEPTH; k++)
            send_word(CMD_LOAD, 4'(k), pick_duration(), 1'b0, UNFIXED);

        first = 1'b1;
        while (words_sent < RANDOM_WORDS + plan.size())
        begin
            if (first || $urandom_range(0, 9) < 6)
                write_reg(REG_PATTERN_LENGTH, pick_length());
            if (first || $urandom_range(0, 9) < 6)
                write_reg(REG_REPEAT_INDEX, pick_repeat());
            first      = 1'b0;
            src_steady = ($urandom_range(0, 5) == 0);

            if ($urandom_range(0, 9) == 0 && rep_val() >= 0)
            begin
                // zero the loop-back region so the jump finds nothing to wait on
                for (int k = rep_val(); k < used_len(); k++)
                    send_word(CMD_LOAD, 4'(k), 16'd0, 1'b0, UNFIXED);
                if (rep_val() > 0)
                    send_word(CMD_LOAD, 4'd1, 16'($urandom_range(1, 3)), 1'b0, UNFIXED);
            end

            r = $urandom_range(0, 3);
            for (int k = 0; k < r; k++)
                send_word(CMD_LOAD, 4'($urandom_range(0, 15)), pick_duration(), 1'b0, UNFIXED);

            if (!squeeze_req)
            begin
                squeeze_req = 1'b1;
                src_steady  = 1'b1;
            end

            send_word(CMD_START, 4'($urandom()), 16'($urandom()), 1'b0, UNFIXED);
            n_ticks = $urandom_range(6, 40);
            for (int k = 0; k < n_ticks; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_word(CMD_CANCEL, 4'($urandom()), 16'($urandom()), 1'b0, UNFIXED);
                else if (r < 8)
                    send_word(CMD_LOAD, 4'($urandom_range(0, 15)), pick_duration(), 1'b0,
                              UNFIXED);
                else if (r < 10)
                    send_word(CMD_START, 4'($urandom()), 16'($urandom()), 1'b0, UNFIXED);
                else
                    send_word(CMD_TICK, 4'($urandom()), 16'($urandom()), 1'b0, UNFIXED);
            end
        end

        s_tvalid <= 1'b0;
        while (motor_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words and %0d register writes, checked %0d result words",
                 words_sent, reg_writes, results_seen);
        $display("saw %0d natural ends, %0d zero-loop stops, %0d rejected starts",
                 natural_ends, zero_loops, rejects);
        if (bad_fields == 0 && motor_words_due.size() == 0)
            $display("vibration_pattern_sequencer_top_tb passed");
        else
            $display("vibration_pattern_sequencer_top_tb failed");
        $finish;
    end

endmodule
